FILE: hw/rtl/three_class_priority_queue_defines.svh
// Assertion macros used by the port-level checker of the priority queue.
`ifndef THREE_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_CLASS_PRIORITY_QUEUE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define TCPQ_ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define TCPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tcpq_pkg.sv
// Shared types, codes and widths of the three-class priority queue.
`timescale 1ns / 1ps

package tcpq_pkg;

    // Field widths of the input and result words.
    localparam int FUNC_W     = 2;
    localparam int ID_W       = 16;
    localparam int CLASS_W    = 2;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Default number of queue slots.
    localparam int DEPTH_DEFAULT = 16;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RECLASS  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // Lowest priority class; larger codes saturate to it.
    localparam logic [CLASS_W-1:0] CLASS_LOWEST = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_req;   // capture the accepted word
        logic                ins;        // insert into the cell row
        logic                use_moved;  // insert the entry taken out before
        logic                disp;       // remove the head
        logic                remove;     // remove the entry at the position
        logic                load_out;   // load the result register
        logic [STATUS_W-1:0] out_status;
    } tcpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              bad_pos;
    } tcpq_stat_t;

endpackage

FILE: hw/rtl/tcpq_ctrl.sv
// Controller state machine of the priority queue.
`timescale 1ns / 1ps

module tcpq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  tcpq_pkg::tcpq_stat_t  stat,
    output tcpq_pkg::tcpq_cmd_t   cmd
);
    import tcpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   out_free;

    // The result register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and datapath commands.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                    unique case (stat.func)
                        FUNC_INSERT: begin
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.ins = 1'b1;
                            end
                        end
                        FUNC_DISPATCH: begin
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.disp = 1'b1;
                            end
                        end
                        FUNC_RECLASS: begin
                            if (stat.bad_pos) begin
                                cmd.out_status = ST_BADPOS;
                            end else begin
                                // Take the entry out now, put it back next cycle.
                                cmd.remove   = 1'b1;
                                cmd.load_out = 1'b0;
                                state_next   = S_REINS;
                            end
                        end
                        FUNC_NOP: begin
                            cmd.out_status = ST_OK;
                        end
                        default: begin
                            cmd.out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_REINS: begin
                cmd.ins       = 1'b1;
                cmd.use_moved = 1'b1;
                cmd.load_out  = 1'b1;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/tcpq_datapath.sv
// Datapath of the priority queue: request register, shifting cell row, result register.
`timescale 1ns / 1ps

module tcpq_datapath #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tcpq_pkg::tcpq_cmd_t            cmd,
    output tcpq_pkg::tcpq_stat_t           stat,
    input  logic [tcpq_pkg::FUNC_W-1:0]    in_func,
    input  logic [tcpq_pkg::ID_W-1:0]      in_id,
    input  logic [tcpq_pkg::CLASS_W-1:0]   in_class,
    input  logic [tcpq_pkg::POS_W-1:0]     in_pos,
    output logic [tcpq_pkg::STATUS_W-1:0]  out_status,
    output logic [tcpq_pkg::ID_W-1:0]      out_id,
    output logic [tcpq_pkg::CLASS_W-1:0]   out_class,
    output logic [tcpq_pkg::FILL_W-1:0]    out_fill
);
    import tcpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Latched request.
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]    id_req_reg;
    logic [CLASS_W-1:0] cls_req_reg;
    logic [POS_W-1:0]   pos_reg;

    // Cell row and fill count.
    logic [ID_W-1:0]    id_cell_reg  [DEPTH];
    logic [CLASS_W-1:0] cls_cell_reg [DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]    moved_reg, moved_next;

    // Result register.
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [CLASS_W-1:0]  out_cls_reg;
    logic [FILL_W-1:0]   fill_reg;

    logic [CMP_W-1:0]   cnt_cmp, pos_cmp, rm_idx;
    logic [ID_W-1:0]    ins_id;
    logic [DEPTH-1:0]   keep, ins_here;
    logic [ID_W-1:0]    up_id  [DEPTH];
    logic [CLASS_W-1:0] up_cls [DEPTH];
    logic [ID_W-1:0]    dn_id  [DEPTH];
    logic [CLASS_W-1:0] dn_cls [DEPTH];

    // Capture the accepted word; classes above the lowest saturate.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            func_reg    <= in_func;
            id_req_reg  <= in_id;
            cls_req_reg <= (in_class > CLASS_LOWEST) ? CLASS_LOWEST : in_class;
            pos_reg     <= in_pos;
        end
    end

    assign cnt_cmp = CMP_W'(count_reg);
    assign pos_cmp = CMP_W'(pos_reg);
    assign rm_idx  = cmd.disp ? '0 : CMP_W'(pos_cmp - CMP_W'(1));
    assign ins_id  = cmd.use_moved ? moved_reg : id_req_reg;

    // Conditions the controller decides on.
    always_comb begin
        stat.func    = func_reg;
        stat.full    = (count_reg == CNT_W'(DEPTH));
        stat.empty   = (count_reg == '0);
        stat.bad_pos = (pos_reg == '0) || (pos_cmp > cnt_cmp);
    end

    // Each cell decides its own move from its neighbors.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        // A held cell of equal or higher class stays ahead of the new entry.
        assign keep[i] = (CMP_W'(i) < cnt_cmp) && (cls_cell_reg[i] <= cls_req_reg);

        if (i == 0) begin : g_first
            assign ins_here[i] = !keep[i];
            assign up_id[i]    = ins_id;
            assign up_cls[i]   = cls_req_reg;
        end else begin : g_rest
            assign ins_here[i] = !keep[i] && keep[i-1];
            assign up_id[i]    = id_cell_reg[i-1];
            assign up_cls[i]   = cls_cell_reg[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign dn_id[i]  = id_cell_reg[i];
            assign dn_cls[i] = cls_cell_reg[i];
        end else begin : g_inner
            assign dn_id[i]  = id_cell_reg[i+1];
            assign dn_cls[i] = cls_cell_reg[i+1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.ins) begin
                if (ins_here[i]) begin
                    id_cell_reg[i]  <= ins_id;
                    cls_cell_reg[i] <= cls_req_reg;
                end else if (!keep[i]) begin
                    id_cell_reg[i]  <= up_id[i];
                    cls_cell_reg[i] <= up_cls[i];
                end
            end else if (cmd.disp || cmd.remove) begin
                if (CMP_W'(i) >= rm_idx) begin
                    id_cell_reg[i]  <= dn_id[i];
                    cls_cell_reg[i] <= dn_cls[i];
                end
            end
        end
    end

    // Pick out the entry being reclassified.
    always_comb begin
        moved_next = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (CMP_W'(k) == rm_idx) begin
                moved_next = moved_next | id_cell_reg[k];
            end
        end
    end

    // Fill count after this cycle's operation.
    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.disp || cmd.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.remove) begin
            moved_reg <= moved_next;
        end
    end

    // Result register; id and class are zero unless the head leaves.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status_reg  <= cmd.out_status;
            out_id_reg  <= cmd.disp ? id_cell_reg[0] : '0;
            out_cls_reg <= cmd.disp ? cls_cell_reg[0] : '0;
            fill_reg    <= FILL_W'(count_next);
        end
    end

    assign out_status = status_reg;
    assign out_id     = out_id_reg;
    assign out_class  = out_cls_reg;
    assign out_fill   = fill_reg;

endmodule

FILE: hw/rtl/three_class_priority_queue.sv
// Top level of the three-class priority queue.
//
//  channel | direction | tdata fields, lowest bit first
//  s_      | in        | func[1:0] entry_id[17:2] member_class[19:18] position[24:20]
//  m_      | out       | status[1:0] out_id[17:2] out_class[19:18] fill_level[24:20]
//
// Insert, dispatch and failed operations accept the word in the idle state, then execute:
// the cell row shifts, unless the operation fails, and the result is loaded. Reclassify
// first closes the gap in the cell row, then inserts the moved entry and loads the result.
// A result waiting in the output register stalls the next operation's execute step.
// Reset is synchronous and clears the fill count and handshake state; no clearing pass.
`timescale 1ns / 1ps

module three_class_priority_queue #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // func, entry_id, member_class, position, zero fill
    input  logic [tcpq_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, out_id, out_class, fill_level, zero fill
    output logic [tcpq_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import tcpq_pkg::*;

    localparam int OUT_USED_W = STATUS_W + ID_W + CLASS_W + FILL_W;

    tcpq_cmd_t  cmd;
    tcpq_stat_t stat;

    logic [STATUS_W-1:0] out_status;
    logic [ID_W-1:0]     out_id;
    logic [CLASS_W-1:0]  out_class;
    logic [FILL_W-1:0]   out_fill;

    // Sequencing of each operation.
    tcpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result formation.
    tcpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tdata[1:0]),
        .in_id      (s_tdata[17:2]),
        .in_class   (s_tdata[19:18]),
        .in_pos     (s_tdata[24:20]),
        .out_status (out_status),
        .out_id     (out_id),
        .out_class  (out_class),
        .out_fill   (out_fill)
    );

    // Pack the result word.
    assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_fill, out_class, out_id, out_status};

endmodule

FILE: hw/rtl/tcpq_checker.sv
// Port-level checker of the priority queue and its binding to the top level.
`timescale 1ns / 1ps
`include "three_class_priority_queue_defines.svh"

module tcpq_port_checker #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcpq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tcpq_pkg::*;

    // A result word stays offered until it is taken.
    `TCPQ_ASSERT_ON(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid, "result word dropped before it was taken")

    // No result word is offered right after reset.
    `TCPQ_ASSERT_ALWAYS(a_reset_quiet, aclk,
        !aresetn |=> !m_tvalid, "result word offered after reset")

    // One operation at a time: the input closes after each accepted word.
    `TCPQ_ASSERT_ON(a_one_at_a_time, aclk, aresetn,
        s_tvalid && s_tready |=> !s_tready, "input accepted two words in a row")

    // A failed result, one whose status is not OK, carries no entry.
    `TCPQ_ASSERT_ON(a_fail_clean, aclk, aresetn,
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[19:2] == '0),
        "failed operation returned an entry")

    // The reported fill level never exceeds the store size.
    `TCPQ_ASSERT_ON(a_fill_bound, aclk, aresetn,
        m_tvalid |-> (int'(m_tdata[24:20]) <= DEPTH), "fill level beyond store size")

endmodule

bind three_class_priority_queue tcpq_port_checker #(.DEPTH(DEPTH)) u_tcpq_checker (.*);

FILE: tb/tcpq_checker.sv
// Checker for the three-class priority queue: predicts every result word and compares it.
`timescale 1ns / 1ps

module tcpq_checker #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // func, entry_id, member_class, position, zero fill
    input  logic [tcpq_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // status, out_id, out_class, fill_level, zero fill
    input  logic [tcpq_pkg::OUT_DATA_W-1:0]  m_tdata,
    output int                               fail_count,
    output int                               pending_results
);
    import tcpq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [CLASS_W-1:0]  cls;
        logic [FILL_W-1:0]   fill;
    } queue_result_t;

    // Shadow copy of the queue contents, head at index 0.
    logic [ID_W-1:0]    shadow_id  [DEPTH];
    logic [CLASS_W-1:0] shadow_cls [DEPTH];
    int                 shadow_n;
    queue_result_t      due_results[$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        shadow_n        = 0;
    end

    // Insert behind every entry of equal or higher class.
    function automatic void shadow_place(input logic [ID_W-1:0] id,
                                         input logic [CLASS_W-1:0] cls);
        int at;
        at = 0;
        while (at < shadow_n && shadow_cls[at] <= cls)
            at++;
        for (int k = shadow_n; k > at; k--) begin
            shadow_id[k]  = shadow_id[k-1];
            shadow_cls[k] = shadow_cls[k-1];
        end
        shadow_id[at]  = id;
        shadow_cls[at] = cls;
        shadow_n++;
    endfunction

    // Close the gap left by the entry at the given index.
    function automatic void shadow_take(input int at);
        for (int k = at; k + 1 < shadow_n; k++) begin
            shadow_id[k]  = shadow_id[k+1];
            shadow_cls[k] = shadow_cls[k+1];
        end
        shadow_n--;
    endfunction

    // Apply one accepted word to the shadow queue and return the expected result.
    function automatic queue_result_t queue_apply(input logic [IN_DATA_W-1:0] w);
        logic [FUNC_W-1:0]  op;
        logic [ID_W-1:0]    id;
        logic [CLASS_W-1:0] cls;
        int                 pos;
        logic [ID_W-1:0]    moved;
        queue_result_t      r;
        op  = w[1:0];
        id  = w[17:2];
        cls = w[19:18];
        pos = int'(w[24:20]);
        // The unused class code counts as the lowest class.
        if (cls > CLASS_LOWEST)
            cls = CLASS_LOWEST;
        r        = '0;
        r.status = ST_OK;
        case (op)
            FUNC_INSERT: begin
                if (shadow_n >= DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_place(id, cls);
            end
            FUNC_DISPATCH: begin
                if (shadow_n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.id  = shadow_id[0];
                    r.cls = shadow_cls[0];
                    shadow_take(0);
                end
            end
            FUNC_RECLASS: begin
                if (pos == 0 || pos > shadow_n) begin
                    r.status = ST_BADPOS;
                end else begin
                    moved = shadow_id[pos-1];
                    shadow_take(pos - 1);
                    shadow_place(moved, cls);
                end
            end
            default: ;
        endcase
        r.fill = FILL_W'(shadow_n);
        return r;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    // Predict on each accepted input word, compare on each accepted result word.
    always @(posedge aclk) begin : watch
        queue_result_t want;
        queue_result_t got;
        if (!aresetn) begin
            shadow_n = 0;
            due_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                due_results.push_back(queue_apply(s_tdata));
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.id     = m_tdata[17:2];
                got.cls    = m_tdata[19:18];
                got.fill   = m_tdata[24:20];
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                        report_field("status", want.status, got.status);
                    if (got.id !== want.id)
                        report_field("out_id", want.id, got.id);
                    if (got.cls !== want.cls)
                        report_field("out_class", want.cls, got.cls);
                    if (got.fill !== want.fill)
                        report_field("fill_level", want.fill, got.fill);
                end
            end
        end
        pending_results = due_results.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top of the three-class priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import tcpq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 356;
    localparam int LONG_HOLD    = 300;

    typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} op_lean_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // func, entry_id, member_class, position, zero fill
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // status, out_id, out_class, fill_level, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_results;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles    = 0;

    always #4 aclk = ~aclk;

    three_class_priority_queue #(
        .DEPTH(DEPTH_DEFAULT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    tcpq_checker #(
        .DEPTH(DEPTH_DEFAULT)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_word(input logic [FUNC_W-1:0] op,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [CLASS_W-1:0] cls,
                                                       input logic [POS_W-1:0] pos);
        return {{(IN_DATA_W - FUNC_W - ID_W - CLASS_W - POS_W){1'b0}}, pos, cls, id, op};
    endfunction

    // Random word whose operation mix leans toward filling, draining or neither.
    function automatic logic [IN_DATA_W-1:0] random_word(input op_lean_t lean);
        int                roll;
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  pos;
        roll = $urandom_range(99);
        case (lean)
            LEAN_FILL:  op = roll < 70 ? FUNC_INSERT : roll < 85 ? FUNC_DISPATCH :
                             roll < 97 ? FUNC_RECLASS : FUNC_NOP;
            LEAN_DRAIN: op = roll < 70 ? FUNC_DISPATCH : roll < 85 ? FUNC_INSERT :
                             roll < 97 ? FUNC_RECLASS : FUNC_NOP;
            default:    op = roll < 35 ? FUNC_INSERT : roll < 70 ? FUNC_DISPATCH :
                             roll < 95 ? FUNC_RECLASS : FUNC_NOP;
        endcase
        // Mostly legal positions, now and then anything the field holds.
        if ($urandom_range(9) == 0)
            pos = POS_W'($urandom_range(31));
        else
            pos = POS_W'($urandom_range(16, 1));
        return pack_word(op, ID_W'($urandom_range(16'hFFFF)), CLASS_W'($urandom_range(3)), pos);
    endfunction

    // Offer one word, idling at random first, and wait until it is taken.
    task automatic send_word(input logic [IN_DATA_W-1:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Hold the sender until every expected result word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_results != 0);
    endtask

    initial begin : stimulus
        int       phase_idle  [4] = '{0, 60, 0, 15};
        int       phase_stall [4] = '{0, 0, 60, 15};
        int       sent;
        int       burst;
        op_lean_t lean;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, no-op, fill to overflow, bad positions, class saturation.
        send_word(pack_word(FUNC_DISPATCH, 16'hFFFF, 2'd3, 5'd31));
        send_word(pack_word(FUNC_RECLASS, 16'h0000, 2'd0, 5'd1));
        send_word(pack_word(FUNC_NOP, 16'hFFFF, 2'd3, 5'd31));
        for (int i = 0; i < 17; i++) begin
            send_word(pack_word(FUNC_INSERT,
                                i == 0 ? 16'h0000 : i == 1 ? 16'hFFFF : ID_W'(i * 16'h0F11),
                                CLASS_W'(i % 4), POS_W'(i)));
        end
        send_word(pack_word(FUNC_RECLASS, 16'h1234, 2'd1, 5'd0));
        send_word(pack_word(FUNC_RECLASS, 16'h1234, 2'd1, 5'd31));
        send_word(pack_word(FUNC_RECLASS, 16'h1234, 2'd0, 5'd16));
        send_word(pack_word(FUNC_RECLASS, 16'h1234, 2'd3, 5'd1));
        send_word(pack_word(FUNC_DISPATCH, 16'h0000, 2'd0, 5'd0));
        wait_drained();

        // Random phases with different idle and stall rates.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            sent      = 0;
            if (ph == 0) begin
                // Receiver holds off while words keep coming, so the input backs up.
                hold_req++;
                for (int i = 0; i < 40; i++)
                    send_word(random_word(LEAN_FILL));
                sent = 40;
            end
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(30, 8);
                lean  = op_lean_t'($urandom_range(2));
                for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
                    send_word(random_word(lean));
                    sent++;
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: three_class_priority_queue.f
+incdir+hw/rtl
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_ctrl.sv
hw/rtl/tcpq_datapath.sv
hw/rtl/three_class_priority_queue.sv
hw/rtl/tcpq_checker.sv
tb/tcpq_checker.sv
tb/tb_top.sv
